[hdl/oaft_pkg.sv]
package oaft_pkg;

    localparam int CMD_W  = 2;
    localparam int TS_W   = 32;
    localparam int FIDX_W = 6;
    localparam int CNT_W  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ACCESS  = 2'd1,
        CMD_EXTRACT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam int CFG_FORGET = 0;
    localparam int CFG_BASE   = 1;

    localparam logic [CNT_W-1:0] ONE_FIXED = 32'h0001_0000;

    typedef struct packed {
        logic [FIDX_W-1:0] index;
        logic [TS_W-1:0]   value;
        logic              last;
    } t_feat;

    // decay counter by interval with window shift sh
    function automatic logic [CNT_W-1:0] decay(input logic [CNT_W-1:0] ctr,
                                               input logic [TS_W-1:0] ivl,
                                               input logic [6:0] sh);
        logic [TS_W-1:0] q;
        q = (sh >= 7'd32) ? '0 : (ivl >> sh[4:0]);
        return (q >= 32'd32) ? '0 : (ctr >> q[4:0]);
    endfunction

endpackage

[hdl/oaft_out_reg.sv]
module oaft_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  oaft_pkg::t_feat     i_feat,
    output logic                o_ready,
    output logic                o_valid,
    output oaft_pkg::t_feat     o_feat,
    input  logic                i_ready
);
    logic r_valid;
    oaft_pkg::t_feat r_feat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_feat  = r_feat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_feat <= i_feat;
        end
    end
endmodule

[hdl/object_access_feature_tracker.sv]
// per item: insert writes the record and each decay counter; access logs the distance and
// updates each counter with a read and a write-back; extract walks the distances read and
// the counters and can stall on the output; an unknown command returns to idle
// one item at a time; ring and counter memories, one read port each, are walked one entry
// at a time, with a read state before each entry is used
// reset: control and configuration registers reset; record memories undefined
module object_access_feature_tracker #(
    parameter int SLOTS              = 1024,
    parameter int HISTORY_DEPTH      = 31,
    parameter int DECAY_COUNTERS     = 10,
    parameter int SIZE_FEATURE_INDEX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], slot[11:2], timestamp[43:12], object_size[75:44], zero[79:76]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // feature_index[5:0], feature_value[37:6], zero[39:38]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int KW = (DECAY_COUNTERS > 1) ? $clog2(DECAY_COUNTERS) : 1;
    localparam int RA = (SLOTS * HISTORY_DEPTH > 1) ? $clog2(SLOTS * HISTORY_DEPTH) : 1;
    localparam int CA = (SLOTS * DECAY_COUNTERS > 1) ? $clog2(SLOTS * DECAY_COUNTERS) : 1;
    // slot reduction by reciprocal multiplication, exact for 10-bit slots
    localparam int SLOT_SH = 10 + SW;
    localparam logic [11:0] SLOT_M =
        12'(((64'd1 << SLOT_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_INS, ST_ACC_RD, ST_ACC_WB, ST_EX_AGE,
        ST_EX_DRD, ST_EX_D, ST_EX_SZ, ST_EX_CNT, ST_EX_KRD, ST_EX_K
    } t_state;

    t_state r_state;
    logic [31:0] r_forget;
    logic [4:0]  r_base;

    logic [oaft_pkg::CMD_W-1:0] r_cmd;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_ts, r_size_in;

    // per-slot memories
    logic [31:0] m_time [SLOTS];
    logic [31:0] m_size [SLOTS];
    logic [HW-1:0] m_ptr [SLOTS];
    logic [HW-1:0] m_cnt [SLOTS];
    logic [31:0] m_ring [SLOTS*HISTORY_DEPTH];
    logic [31:0] m_ctr  [SLOTS*DECAY_COUNTERS];

    logic [31:0] r_time_q, r_size_q, r_ring_q, r_ctr_q;
    logic [HW-1:0] r_ptr_q, r_cnt_q;

    logic [HW-1:0] r_j, r_ridx;
    logic [KW-1:0] r_k;
    logic [31:0]   r_dist;
    logic [32:0]   r_sum;

    logic          r_hold_valid, h_ready;
    oaft_pkg::t_feat r_hold_feat, o_feat;

    logic [31:0] w_age;
    assign w_age = r_ts - r_time_q;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    logic [9:0]  w_in_slot;
    logic [21:0] w_slot_prod;
    logic [9:0]  w_slot_quo;
    logic [9:0]  w_slot_rem;
    assign w_in_slot   = s_axis_tdata[11:2];
    assign w_slot_prod = 22'(w_in_slot) * 22'(SLOT_M);
    assign w_slot_quo  = 10'(w_slot_prod >> SLOT_SH);
    assign w_slot_rem  = w_in_slot - 10'(32'(w_slot_quo) * 32'(SLOTS));

    logic [RA-1:0] w_raddr;
    logic [CA-1:0] w_caddr;
    assign w_raddr = RA'(r_slot) * RA'(HISTORY_DEPTH) + RA'(r_ridx);
    assign w_caddr = CA'(r_slot) * CA'(DECAY_COUNTERS) + CA'(r_k);

    logic [6:0]  w_sh;
    logic [31:0] w_dec, w_acc_new;
    assign w_sh  = 7'(r_base) + 7'(r_k);
    assign w_dec = oaft_pkg::decay(r_ctr_q, (r_state == ST_ACC_WB) ? r_dist : w_age, w_sh);
    assign w_acc_new = (w_dec > 32'hFFFF_FFFF - oaft_pkg::ONE_FIXED) ? 32'hFFFF_FFFF
                                                                    : w_dec + oaft_pkg::ONE_FIXED;

    logic [32:0] w_nsum;
    assign w_nsum = r_sum + 33'(r_ring_q);

    // a feature beat is loaded into the holding register this cycle
    logic w_hold_free, w_emit;
    assign w_hold_free = !r_hold_valid || h_ready;
    assign w_emit = w_hold_free && ((r_state == ST_EX_AGE) || (r_state == ST_EX_SZ)
                                    || (r_state == ST_EX_CNT) || (r_state == ST_EX_K)
                                    || ((r_state == ST_EX_D) && (w_nsum < 33'(r_forget))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forget <= 32'd80000000;
            r_base   <= 5'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                1'(oaft_pkg::CFG_FORGET): r_forget <= i_cfg_data;
                default:                  r_base   <= i_cfg_data[4:0];
            endcase
        end
    end

    // memory read ports
    always_ff @(posedge i_clk) begin
        r_time_q <= m_time[r_slot];
        r_size_q <= m_size[r_slot];
        r_ptr_q  <= m_ptr[r_slot];
        r_cnt_q  <= m_cnt[r_slot];
        r_ring_q <= m_ring[w_raddr];
        r_ctr_q  <= m_ctr[w_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hold_valid <= 1'b0;
        end else begin
            if (w_emit) r_hold_valid <= 1'b1;
            else if (h_ready) r_hold_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_cmd     <= s_axis_tdata[1:0];
                    r_slot    <= SW'(w_slot_rem);
                    r_ts      <= s_axis_tdata[43:12];
                    r_size_in <= s_axis_tdata[75:44];
                    r_k       <= '0;
                    r_j       <= '0;
                    r_sum     <= '0;
                    r_state   <= ST_RD;
                end
                ST_RD: begin
                    unique case (r_cmd)
                        oaft_pkg::CMD_INSERT:  r_state <= ST_INS;
                        oaft_pkg::CMD_ACCESS:  r_state <= ST_ACC_RD;
                        oaft_pkg::CMD_EXTRACT: r_state <= ST_EX_AGE;
                        default:               r_state <= ST_IDLE;
                    endcase
                end
                ST_INS: begin
                    m_time[r_slot] <= r_ts;
                    m_size[r_slot] <= r_size_in;
                    m_ptr[r_slot]  <= '0;
                    m_cnt[r_slot]  <= '0;
                    m_ctr[w_caddr] <= oaft_pkg::ONE_FIXED;
                    if (r_k == KW'(DECAY_COUNTERS - 1)) r_state <= ST_IDLE;
                    else r_k <= r_k + 1'b1;
                end
                ST_ACC_RD: begin
                    if (r_k == '0) begin
                        r_dist <= w_age;
                        m_ring[RA'(r_slot) * RA'(HISTORY_DEPTH) + RA'(r_ptr_q)] <= w_age;
                        m_ptr[r_slot] <= (r_ptr_q == HW'(HISTORY_DEPTH - 1)) ? '0
                                                                             : r_ptr_q + 1'b1;
                        if (r_cnt_q < HW'(HISTORY_DEPTH)) m_cnt[r_slot] <= r_cnt_q + 1'b1;
                        m_time[r_slot] <= r_ts;
                    end
                    r_state <= ST_ACC_WB;
                end
                ST_ACC_WB: begin
                    m_ctr[w_caddr] <= w_acc_new;
                    if (r_k == KW'(DECAY_COUNTERS - 1)) r_state <= ST_IDLE;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_state <= ST_ACC_RD;
                    end
                end
                ST_EX_AGE: if (w_hold_free) begin
                    r_hold_feat <= '{index: '0, value: w_age, last: 1'b0};
                    r_ts    <= w_age;
                    r_ridx  <= (r_ptr_q == '0) ? HW'(HISTORY_DEPTH - 1) : r_ptr_q - 1'b1;
                    r_state <= (r_cnt_q == '0) ? ST_EX_SZ : ST_EX_DRD;
                end
                ST_EX_DRD: r_state <= ST_EX_D;
                ST_EX_D: if (w_hold_free) begin
                    r_sum <= w_nsum;
                    if (w_nsum >= 33'(r_forget)) begin
                        r_state <= ST_EX_SZ;
                    end else begin
                        r_hold_feat <= '{index: oaft_pkg::FIDX_W'(r_j + 1'b1),
                                         value: r_ring_q, last: 1'b0};
                        r_j     <= r_j + 1'b1;
                        r_ridx  <= (r_ridx == '0) ? HW'(HISTORY_DEPTH - 1) : r_ridx - 1'b1;
                        r_state <= (r_j + 1'b1 == r_cnt_q) ? ST_EX_SZ : ST_EX_DRD;
                    end
                end
                ST_EX_SZ: if (w_hold_free) begin
                    r_hold_feat <= '{index: oaft_pkg::FIDX_W'(SIZE_FEATURE_INDEX),
                                     value: r_size_q, last: 1'b0};
                    r_state <= ST_EX_CNT;
                end
                ST_EX_CNT: if (w_hold_free) begin
                    r_hold_feat <= '{index: oaft_pkg::FIDX_W'(SIZE_FEATURE_INDEX + 1),
                                     value: 32'(r_j), last: 1'b0};
                    r_state <= ST_EX_KRD;
                end
                ST_EX_KRD: r_state <= ST_EX_K;
                ST_EX_K: if (w_hold_free) begin
                    r_hold_feat <= '{index: oaft_pkg::FIDX_W'(SIZE_FEATURE_INDEX + 2 + 32'(r_k)),
                                     value: oaft_pkg::decay(r_ctr_q, r_ts, w_sh),
                                     last: (r_k == KW'(DECAY_COUNTERS - 1))};
                    if (r_k == KW'(DECAY_COUNTERS - 1)) r_state <= ST_IDLE;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_state <= ST_EX_KRD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    oaft_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_hold_valid),
        .i_feat  (r_hold_feat),
        .o_ready (h_ready),
        .o_valid (m_axis_tvalid),
        .o_feat  (o_feat),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, o_feat.value, o_feat.index};
    assign m_axis_tlast = o_feat.last;
endmodule
